FILE: design/stride_prefetch_generator_defines.svh
// Assertion macros, included by spg_back.sv.
`ifndef STRIDE_PREFETCH_GENERATOR_DEFINES_SVH
`define STRIDE_PREFETCH_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SPG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPG_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPG_ASSERT(label, clk, rst_n, prop, msg)
`define SPG_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

FILE: design/spg_pkg.sv
package spg_pkg;

  localparam int SpgAddrBits  = 32;
  localparam int SpgMaxDegree = 32;

  localparam int IoAddrW   = 32;
  localparam int DegRegW   = 6;
  localparam int DegCmpW   = 7;
  localparam int ThrW      = 8;
  localparam int LimitW    = 32;
  localparam int PaddrW    = 4;
  localparam int PdataW    = 32;
  localparam int JobDepth  = 2;

  localparam logic [DegRegW-1:0] DegreeRst = 6'd15;
  localparam logic [ThrW-1:0]    ThrRst    = 8'd4;
  localparam logic [LimitW-1:0]  LimitRst  = 32'hFFFF_FFFF;
  localparam logic [ThrW-1:0]    RunMax    = 8'hFF;

  typedef enum logic [1:0] {
    REG_DEGREE    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_LIMIT     = 2'd2
  } reg_idx_e;

endpackage

FILE: design/spg_front.sv
module spg_front #(
  parameter int ADDR_BITS  = spg_pkg::SpgAddrBits,
  parameter int MAX_DEGREE = spg_pkg::SpgMaxDegree,
  parameter int DEG_W      = $clog2(MAX_DEGREE + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         is_miss_i,
  input  logic [spg_pkg::IoAddrW-1:0]  access_address_i,
  input  logic [spg_pkg::DegRegW-1:0]  degree_i,
  input  logic [spg_pkg::ThrW-1:0]     threshold_i,
  output logic                         job_push_o,
  input  logic                         job_full_i,
  output logic [ADDR_BITS-1:0]         job_base_o,
  output logic [ADDR_BITS-1:0]         job_stride_o,
  output logic [DEG_W-1:0]             job_deg_o
);

  localparam logic [spg_pkg::DegCmpW-1:0] MaxDegC = spg_pkg::DegCmpW'(MAX_DEGREE);

  logic                     have_q, have_d;
  logic [ADDR_BITS-1:0]     prev_q, prev_d;
  logic [ADDR_BITS-1:0]     stride_q, stride_d;
  logic [spg_pkg::ThrW-1:0] count_q, count_d;
  logic [ADDR_BITS-1:0]     end_q, end_d;
  logic                     pend_q, pend_d;

  logic [ADDR_BITS-1:0]         addr;
  logic [ADDR_BITS-1:0]         from_miss, from_end, prod;
  logic [spg_pkg::DegCmpW-1:0]  deg_ext, deg_sat;
  logic                         accept, match, trig;

  if (ADDR_BITS <= spg_pkg::IoAddrW) begin : g_addr_narrow
    assign addr = access_address_i[ADDR_BITS-1:0];
  end else begin : g_addr_wide
    assign addr = {{(ADDR_BITS - spg_pkg::IoAddrW){1'b0}}, access_address_i};
  end

  assign deg_ext   = {1'b0, degree_i};
  assign deg_sat   = (deg_ext > MaxDegC) ? MaxDegC : deg_ext;
  assign job_deg_o = deg_sat[DEG_W-1:0];

  // run end is settled in the cycle after a triggering miss; hold off input meanwhile
  assign full_o = job_full_i || pend_q;
  assign accept = push_i && !full_o;

  assign from_miss = addr - prev_q;
  assign from_end  = addr - end_q;
  assign match     = (from_miss == stride_q) || (from_end == stride_q);
  assign prod      = stride_q * ADDR_BITS'(job_deg_o);

  always_comb begin
    have_d   = have_q;
    prev_d   = prev_q;
    stride_d = stride_q;
    count_d  = count_q;
    end_d    = end_q;
    pend_d   = 1'b0;
    trig     = 1'b0;
    if (pend_q) begin
      end_d = prev_q + prod;
    end
    if (accept && is_miss_i) begin
      have_d = 1'b1;
      prev_d = addr;
      if (have_q) begin
        if (match) begin
          if (count_q != spg_pkg::RunMax) begin
            count_d = count_q + spg_pkg::ThrW'(1);
          end
        end else begin
          stride_d = from_miss;
          count_d  = '0;
        end
      end
      trig   = (count_d >= threshold_i);
      pend_d = trig;
    end
  end

  assign job_push_o   = trig && (job_deg_o != '0);
  assign job_base_o   = addr;
  assign job_stride_o = stride_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      prev_q   <= '0;
      stride_q <= '0;
      count_q  <= '0;
      end_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      have_q   <= have_d;
      prev_q   <= prev_d;
      stride_q <= stride_d;
      count_q  <= count_d;
      end_q    <= end_d;
      pend_q   <= pend_d;
    end
  end

endmodule

FILE: design/spg_queue.sv
module spg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = spg_pkg::JobDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: design/spg_back.sv
`include "stride_prefetch_generator_defines.svh"

module spg_back #(
  parameter int ADDR_BITS = spg_pkg::SpgAddrBits,
  parameter int DEG_W     = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_empty_i,
  output logic                         job_pop_o,
  input  logic [ADDR_BITS-1:0]         job_base_i,
  input  logic [ADDR_BITS-1:0]         job_stride_i,
  input  logic [DEG_W-1:0]             job_deg_i,
  input  logic [spg_pkg::LimitW-1:0]   limit_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [spg_pkg::IoAddrW-1:0]  prefetch_address_o,
  output logic                         issue_ok_o,
  output logic                         last_of_run_o
);

  logic                        busy_q;
  logic [ADDR_BITS-1:0]        cand_q, step_q;
  logic [DEG_W-1:0]            idx_q, deg_q;
  logic                        out_valid_q;
  logic [spg_pkg::IoAddrW-1:0] out_addr_q;
  logic                        out_ok_q, out_last_q;

  logic                        out_free, emit, last, cand_ok;
  logic [spg_pkg::IoAddrW-1:0] cand_out;

  if (ADDR_BITS >= spg_pkg::IoAddrW) begin : g_cmp_wide
    assign cand_ok  = (cand_q <= ADDR_BITS'(limit_i));
    assign cand_out = cand_q[spg_pkg::IoAddrW-1:0];
  end else begin : g_cmp_narrow
    assign cand_ok  = ({{(spg_pkg::IoAddrW - ADDR_BITS){1'b0}}, cand_q} <= limit_i);
    assign cand_out = {{(spg_pkg::IoAddrW - ADDR_BITS){1'b0}}, cand_q};
  end

  assign out_free  = !out_valid_q || pop_i;
  assign job_pop_o = !busy_q && !job_empty_i;
  assign emit      = busy_q && out_free;
  assign last      = (idx_q == deg_q);

  // candidate walk: one address per beat while the output register is free, stride added each step
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cand_q <= job_base_i + job_stride_i;
      step_q <= job_stride_i;
      deg_q  <= job_deg_i;
      idx_q  <= DEG_W'(1);
    end else if (emit) begin
      cand_q <= cand_q + step_q;
      idx_q  <= idx_q + DEG_W'(1);
    end
    if (emit) begin
      out_addr_q <= cand_out;
      out_ok_q   <= cand_ok;
      out_last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && last) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o            = !out_valid_q;
  assign prefetch_address_o = out_addr_q;
  assign issue_ok_o         = out_ok_q;
  assign last_of_run_o      = out_last_q;

  `SPG_ASSERT(a_idx_range, clk_i, rst_ni, busy_q |-> (idx_q != '0) && (idx_q <= deg_q), "candidate index out of range")
  `SPG_ASSERT(a_run_done, clk_i, rst_ni, (emit && last) |=> !busy_q, "walker still busy after last beat")
  `SPG_ASSERT(a_emit_lands, clk_i, rst_ni, emit |=> out_valid_q, "emitted beat not held in output register")

endmodule

FILE: design/stride_prefetch_generator.sv
// Stride prefetch generator. A hit or a miss that does not reach the run threshold
// leaves no result. A miss that triggers a run holds the input off while the run
// end (miss address plus degree times stride, one multiply) is updated, and queues
// a job for the candidate walker unless the degree is zero. The walker loads a job
// and then produces one candidate per cycle while the output register is free, and
// it takes a new job only after the last candidate of its current job. A two-entry
// job queue lets the front keep taking beats while the walker drains. Results
// leave through a single output register. Registers: prefetch_degree at 0x0,
// run_threshold at 0x4, address_limit at 0x8; write them only while the block
// is idle.
module stride_prefetch_generator #(
  parameter int ADDR_BITS  = spg_pkg::SpgAddrBits,
  parameter int MAX_DEGREE = spg_pkg::SpgMaxDegree
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spg_pkg::PaddrW-1:0]   paddr,
  input  logic [spg_pkg::PdataW-1:0]   pwdata,
  output logic [spg_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic                         is_miss_i,
  input  logic [spg_pkg::IoAddrW-1:0]  access_address_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [spg_pkg::IoAddrW-1:0]  prefetch_address_o,
  output logic                         issue_ok_o,
  output logic                         last_of_run_o
);

  localparam int DegW = $clog2(MAX_DEGREE + 1);
  localparam int JobW = 2 * ADDR_BITS + DegW;

  logic [spg_pkg::DegRegW-1:0] degree_q;
  logic [spg_pkg::ThrW-1:0]    threshold_q;
  logic [spg_pkg::LimitW-1:0]  limit_q;

  spg_pkg::reg_idx_e reg_idx;
  logic              cfg_wr;

  logic                 job_push, job_full, job_pop, job_empty;
  logic [ADDR_BITS-1:0] f_base, f_stride, b_base, b_stride;
  logic [DegW-1:0]      f_deg, b_deg;
  logic [JobW-1:0]      job_wdata, job_rdata;

  assign reg_idx = spg_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q    <= spg_pkg::DegreeRst;
      threshold_q <= spg_pkg::ThrRst;
      limit_q     <= spg_pkg::LimitRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        spg_pkg::REG_DEGREE:    degree_q    <= pwdata[spg_pkg::DegRegW-1:0];
        spg_pkg::REG_THRESHOLD: threshold_q <= pwdata[spg_pkg::ThrW-1:0];
        spg_pkg::REG_LIMIT:     limit_q     <= pwdata[spg_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spg_pkg::REG_DEGREE:    prdata = spg_pkg::PdataW'(degree_q);
      spg_pkg::REG_THRESHOLD: prdata = spg_pkg::PdataW'(threshold_q);
      spg_pkg::REG_LIMIT:     prdata = spg_pkg::PdataW'(limit_q);
      default:                prdata = '0;
    endcase
  end

  spg_front #(
    .ADDR_BITS  (ADDR_BITS),
    .MAX_DEGREE (MAX_DEGREE),
    .DEG_W      (DegW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .is_miss_i        (is_miss_i),
    .access_address_i (access_address_i),
    .degree_i         (degree_q),
    .threshold_i      (threshold_q),
    .job_push_o       (job_push),
    .job_full_i       (job_full),
    .job_base_o       (f_base),
    .job_stride_o     (f_stride),
    .job_deg_o        (f_deg)
  );

  assign job_wdata = {f_base, f_stride, f_deg};
  assign {b_base, b_stride, b_deg} = job_rdata;

  spg_queue #(
    .WIDTH (JobW),
    .DEPTH (spg_pkg::JobDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .full_o  (job_full),
    .wdata_i (job_wdata),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .rdata_o (job_rdata)
  );

  spg_back #(
    .ADDR_BITS (ADDR_BITS),
    .DEG_W     (DegW)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_empty_i        (job_empty),
    .job_pop_o          (job_pop),
    .job_base_i         (b_base),
    .job_stride_i       (b_stride),
    .job_deg_i          (b_deg),
    .limit_i            (limit_q),
    .pop_i              (pop),
    .empty_o            (empty),
    .prefetch_address_o (prefetch_address_o),
    .issue_ok_o         (issue_ok_o),
    .last_of_run_o      (last_of_run_o)
  );

endmodule
